// ===== src/b64d_pkg.sv =====
// b64d_pkg: shared types, character codes and the alphabet lookup
// for the base64 stream decoder; no dependencies
package b64d_pkg;

	localparam int QDEPTH = 4;

	localparam logic [7:0] CH_UP_A = 8'h41;
	localparam logic [7:0] CH_UP_Z = 8'h5a;
	localparam logic [7:0] CH_LO_A = 8'h61;
	localparam logic [7:0] CH_LO_Z = 8'h7a;
	localparam logic [7:0] CH_D0   = 8'h30;
	localparam logic [7:0] CH_D9   = 8'h39;
	localparam logic [7:0] CH_PLUS = 8'h2b;
	localparam logic [7:0] CH_SLASH = 8'h2f;

	localparam logic [7:0] OFS_LO = 8'd26;
	localparam logic [7:0] OFS_DIG = 8'd52;
	localparam logic [5:0] SX_PLUS = 6'd62;
	localparam logic [5:0] SX_SLASH = 6'd63;

	// one queue entry: up to three bytes, msb byte first
	typedef struct packed {
		logic [23:0] word;
		logic [1:0]  nbytes;
		logic        done;
	} group_t;

	typedef struct packed {
		logic   ok;
		logic [5:0] val;
	} sextet_t;

	function automatic sextet_t sextet_of(input logic [7:0] c);
		sextet_t    r;
		logic [7:0] t;
		r = '{ok: 1'b0, val: 6'd0};
		t = 8'd0;
		if (c >= CH_UP_A && c <= CH_UP_Z) begin
			t = c - CH_UP_A;
			r = '{ok: 1'b1, val: t[5:0]};
		end else if (c >= CH_LO_A && c <= CH_LO_Z) begin
			t = c - CH_LO_A + OFS_LO;
			r = '{ok: 1'b1, val: t[5:0]};
		end else if (c >= CH_D0 && c <= CH_D9) begin
			t = c - CH_D0 + OFS_DIG;
			r = '{ok: 1'b1, val: t[5:0]};
		end else if (c == CH_PLUS) begin
			r = '{ok: 1'b1, val: SX_PLUS};
		end else if (c == CH_SLASH) begin
			r = '{ok: 1'b1, val: SX_SLASH};
		end
		return r;
	endfunction

endpackage

// ===== src/b64d_if.sv =====
// b64d_if: valid/ready channel interfaces for characters in and bytes out
// no dependencies
interface b64d_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_char;
	logic       end_of_text;
	modport source (output valid, in_char, end_of_text, input ready);
	modport sink   (input valid, in_char, end_of_text, output ready);
endinterface

interface b64d_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       byte_valid;
	logic       run_last;
	logic       string_done;
	modport source (output valid, out_byte, byte_valid, run_last, string_done, input ready);
	modport sink   (input valid, out_byte, byte_valid, run_last, string_done, output ready);
endinterface

// ===== src/base64_stream_decoder.sv =====
// base64_stream_decoder: top level of the streaming base64 decoder
// depends on b64d_pkg, b64d_if, b64d_front, b64d_queue, b64d_back
//
//  channel | dir | payload                                        | note
//  chars   | in  | in_char[7:0], end_of_text                      | one character a word
//  bytes   | out | out_byte[7:0], byte_valid, run_last, string_done | one byte a word
//
// a character is taken every cycle while the group queue has room; the front
// end settles it in the same cycle and queues zero to three bytes as a group
// the back end sends one byte a cycle unless stalled, so a full group holds the queue
// head until all three are sent; the queue depth sets how long input rides through
// reset clears sextet store, count, halt flag, queue pointers and the output flag
// a stalled output only backs up into the queue; input stops once it is full
module base64_stream_decoder
	import b64d_pkg::*;
#(
	parameter int QUEUE_DEPTH = QDEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	b64d_in_if.sink    chars,
	b64d_out_if.source bytes
);

	logic   full;
	logic   empty;
	logic   acc;
	logic   push;
	logic   pop;
	group_t grp;
	group_t head;

	// take a character whenever a group can be queued
	assign chars.ready = !full;
	assign acc = chars.valid && !full;

	// front end: classify and gather sextets
	b64d_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.acc         (acc),
		.in_char     (chars.in_char),
		.end_of_text (chars.end_of_text),
		.push        (push),
		.grp         (grp)
	);

	// decoupling queue between the two halves
	b64d_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (grp),
		.pop    (pop),
		.head   (head),
		.full   (full),
		.empty  (empty)
	);

	// back end: one byte a cycle to the output register, unless the output stalls
	b64d_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.empty  (empty),
		.pop    (pop),
		.bytes  (bytes)
	);

endmodule

// ===== src/b64d_front.sv =====
// b64d_front: classifies characters, gathers sextets and forms byte groups
// depends on b64d_pkg
module b64d_front
	import b64d_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       acc,
	input  logic [7:0] in_char,
	input  logic       end_of_text,
	output logic       push,
	output group_t     grp
);

	logic [17:0] store_q;
	logic [1:0]  cnt_q;
	logic        halted_q;

	sextet_t     sx;
	logic [17:0] ns;
	logic [1:0]  ncnt;
	logic [17:0] st_nxt;
	logic [1:0]  cnt_nxt;
	logic        halt_nxt;

	// left-align an open group and give count minus one bytes
	function automatic group_t flush(input logic [17:0] s, input logic [1:0] c);
		group_t g;
		g = '{word: 24'd0, nbytes: 2'd0, done: 1'b0};
		unique case (c)
			2'd2: g = '{word: {s[11:0], 12'd0}, nbytes: 2'd1, done: 1'b0};
			2'd3: g = '{word: {s, 6'd0}, nbytes: 2'd2, done: 1'b0};
			default: g = '{word: 24'd0, nbytes: 2'd0, done: 1'b0};
		endcase
		return g;
	endfunction

	always_comb begin
		sx = sextet_of(in_char);
		ns = {store_q[11:0], sx.val};
		ncnt = cnt_q + 2'd1;
		grp = '{word: 24'd0, nbytes: 2'd0, done: 1'b0};
		st_nxt = store_q;
		cnt_nxt = cnt_q;
		halt_nxt = halted_q;
		if (!halted_q) begin
			if (!sx.ok) begin
				grp = flush(store_q, cnt_q);
				st_nxt = 18'd0;
				cnt_nxt = 2'd0;
				halt_nxt = 1'b1;
			end else if (cnt_q == 2'd3) begin
				grp = '{word: {store_q, sx.val}, nbytes: 2'd3, done: 1'b0};
				st_nxt = 18'd0;
				cnt_nxt = 2'd0;
			end else begin
				st_nxt = ns;
				cnt_nxt = ncnt;
				if (end_of_text)
					grp = flush(ns, ncnt);
			end
		end
		if (end_of_text) begin
			grp.done = 1'b1;
			st_nxt = 18'd0;
			cnt_nxt = 2'd0;
			halt_nxt = 1'b0;
		end
		push = acc && (grp.nbytes != 2'd0 || grp.done);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			store_q <= 18'd0;
			cnt_q <= 2'd0;
			halted_q <= 1'b0;
		end else if (acc) begin
			store_q <= st_nxt;
			cnt_q <= cnt_nxt;
			halted_q <= halt_nxt;
		end
	end

endmodule

// ===== src/b64d_queue.sv =====
// b64d_queue: small first-in first-out queue of byte groups
// depends on b64d_pkg
module b64d_queue
	import b64d_pkg::*;
#(
	parameter int DEPTH = QDEPTH
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  group_t wdata,
	input  logic   pop,
	output group_t head,
	output logic   full,
	output logic   empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULLCNT = CW'(DEPTH);

	group_t        mem [DEPTH];
	logic [AW-1:0] wp_q;
	logic [AW-1:0] rp_q;
	logic [CW-1:0] cnt_q;

	assign full = (cnt_q == FULLCNT);
	assign empty = (cnt_q == '0);
	assign head = mem[rp_q];

	always_ff @(posedge clk) begin
		if (push)
			mem[wp_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wp_q <= (wp_q == LAST) ? '0 : wp_q + AW'(1);
			if (pop)
				rp_q <= (rp_q == LAST) ? '0 : rp_q + AW'(1);
			if (push && !pop)
				cnt_q <= cnt_q + CW'(1);
			else if (pop && !push)
				cnt_q <= cnt_q - CW'(1);
		end
	end

endmodule

// ===== src/b64d_back.sv =====
// b64d_back: splits byte groups into single results behind an output register
// depends on b64d_pkg and b64d_if
module b64d_back
	import b64d_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  group_t        head,
	input  logic          empty,
	output logic          pop,
	b64d_out_if.source    bytes
);

	logic [1:0] k_q;
	logic       ovalid_q;
	logic [7:0] byte_q;
	logic       bval_q;
	logic       rlast_q;
	logic       sdone_q;

	logic       load;
	logic       lastb;
	logic [7:0] sel;

	always_comb begin
		load = !empty && (!ovalid_q || bytes.ready);
		unique case (k_q)
			2'd0: sel = head.word[23:16];
			2'd1: sel = head.word[15:8];
			default: sel = head.word[7:0];
		endcase
		// an empty group is the end marker and counts as its own last result
		lastb = (head.nbytes == 2'd0) || (k_q == head.nbytes - 2'd1);
		pop = load && lastb;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q <= 2'd0;
			ovalid_q <= 1'b0;
		end else begin
			if (load)
				k_q <= lastb ? 2'd0 : k_q + 2'd1;
			if (load)
				ovalid_q <= 1'b1;
			else if (bytes.ready)
				ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q <= (head.nbytes == 2'd0) ? 8'd0 : sel;
			bval_q <= (head.nbytes != 2'd0);
			rlast_q <= lastb;
			sdone_q <= lastb && head.done;
		end
	end

	assign bytes.valid = ovalid_q;
	assign bytes.out_byte = byte_q;
	assign bytes.byte_valid = bval_q;
	assign bytes.run_last = rlast_q;
	assign bytes.string_done = sdone_q;

endmodule

// ===== tb/tb_base64_stream_decoder.sv =====
// tb_base64_stream_decoder: self-checking testbench for the base64 stream decoder
// depends on b64d_pkg, b64d_if and base64_stream_decoder; a class tracks decoded bytes
module tb_base64_stream_decoder;
	import b64d_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [7:0] CH_PAD    = 8'h3d;
	localparam int         HOLD_LEN  = 90;
	localparam int         HOLD_AT   = 60;
	localparam int         TEXT_GOAL = 280;
	localparam int         DRAIN_MAX = 5000;

	// one decoded byte word as the output channel carries it
	typedef struct packed {
		logic [7:0] data;
		logic       has_data;
		logic       item_end;
		logic       text_end;
	} dec_word_t;

	// mirrors the decoder state and holds the bytes still owed by the block
	class byte_tracker;
		logic [17:0] sx_store;
		logic [1:0]  sx_count;
		bit          stopped;
		dec_word_t   burst[$];
		dec_word_t   owed[$];
		int          failures;
		int          checked;
		int          markers;

		// alphabet lookup, bit 6 set for a legal character
		function logic [6:0] char_code(input logic [7:0] c);
			logic [7:0] t;
			t = 8'd0;
			if (c >= CH_UP_A && c <= CH_UP_Z)
				t = c - CH_UP_A;
			else if (c >= CH_LO_A && c <= CH_LO_Z)
				t = c - CH_LO_A + 8'd26;
			else if (c >= CH_D0 && c <= CH_D9)
				t = c - CH_D0 + 8'd52;
			else if (c == CH_PLUS)
				t = 8'd62;
			else if (c == CH_SLASH)
				t = 8'd63;
			else
				return 7'd0;
			return {1'b1, t[5:0]};
		endfunction

		function void push_data(input logic [7:0] b);
			burst.push_back('{data: b, has_data: 1'b1, item_end: 1'b0, text_end: 1'b0});
		endfunction

		// open group gives count minus one bytes, msb first
		function void flush_open();
			logic [23:0] full;
			int          cnt;
			cnt = sx_count;
			if (cnt >= 2) begin
				full = {6'd0, sx_store} << (6 * (4 - cnt));
				for (int k = 0; k < cnt - 1; k++)
					push_data(full[23 - 8 * k -: 8]);
			end
			sx_store = '0;
			sx_count = '0;
		endfunction

		function void note_char(input logic [7:0] c, input logic eot);
			logic [6:0]  code;
			logic [23:0] full;
			burst.delete();
			if (!stopped) begin
				code = char_code(c);
				if (!code[6]) begin
					flush_open();
					stopped = 1'b1;
				end else if (sx_count == 2'd3) begin
					full = {sx_store, code[5:0]};
					push_data(full[23:16]);
					push_data(full[15:8]);
					push_data(full[7:0]);
					sx_store = '0;
					sx_count = '0;
				end else begin
					sx_store = {sx_store[11:0], code[5:0]};
					sx_count = sx_count + 2'd1;
				end
			end
			if (eot) begin
				if (!stopped)
					flush_open();
				if (burst.size() == 0) begin
					burst.push_back('{data: 8'd0, has_data: 1'b0, item_end: 1'b0,
						text_end: 1'b0});
					markers++;
				end
				burst[burst.size() - 1].text_end = 1'b1;
				sx_store = '0;
				sx_count = '0;
				stopped = 1'b0;
			end
			if (burst.size() > 0)
				burst[burst.size() - 1].item_end = 1'b1;
			foreach (burst[i])
				owed.push_back(burst[i]);
		endfunction

		function void check_word(input dec_word_t got);
			dec_word_t want;
			checked++;
			if (owed.size() == 0) begin
				failures++;
				if (failures <= 10)
					$display("error: unexpected word data=%02h has_data=%0b run_last=%0b done=%0b",
						got.data, got.has_data, got.item_end, got.text_end);
				return;
			end
			want = owed.pop_front();
			if (got.data !== want.data || got.has_data !== want.has_data ||
					got.item_end !== want.item_end || got.text_end !== want.text_end) begin
				failures++;
				if (failures <= 10)
					$display("error: word %0d expected %02h/%0b/%0b/%0b got %02h/%0b/%0b/%0b",
						checked, want.data, want.has_data, want.item_end, want.text_end,
						got.data, got.has_data, got.item_end, got.text_end);
			end
		endfunction

		function bit idle();
			return owed.size() == 0;
		endfunction
	endclass

	logic clk;
	logic arst_n;

	b64d_in_if  chars ();
	b64d_out_if bytes ();

	base64_stream_decoder i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.chars  (chars),
		.bytes  (bytes)
	);

	byte_tracker tracker;
	string       alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
	int          chars_sent;
	int          texts_sent;
	bit          calm;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// mostly back to back, some short gaps, a few long ones; none while calm
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// offer one character word and wait for it to be taken
	task automatic send_char(input logic [7:0] c, input logic eot);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			chars.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		chars.valid       <= 1'b1;
		chars.in_char     <= c;
		chars.end_of_text <= eot;
		do
			@(posedge clk);
		while (!chars.ready);
		tracker.note_char(c, eot);
		chars_sent++;
		if (eot)
			texts_sent++;
	endtask

	// directed strings, end flag on the last character
	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_char(s[i], i == s.len() - 1);
	endtask

	function automatic logic [7:0] any_legal();
		return alphabet[$urandom_range(0, 63)];
	endfunction

	// well-formed text: full groups, a tail usually with matching padding, maybe one junk character after
	task automatic send_good_text();
		logic [7:0] buf_q[$];
		int         tail;
		repeat ($urandom_range(0, 3))
			repeat (4)
				buf_q.push_back(any_legal());
		tail = $urandom_range(0, 3);
		repeat (tail)
			buf_q.push_back(any_legal());
		if ($urandom_range(0, 3) != 0) begin
			if (tail == 2) begin
				buf_q.push_back(CH_PAD);
				buf_q.push_back(CH_PAD);
			end else if (tail == 3) begin
				buf_q.push_back(CH_PAD);
			end
		end
		repeat ($urandom_range(0, 4) / 3)
			buf_q.push_back(8'($urandom_range(0, 255)));
		if (buf_q.size() == 0)
			buf_q.push_back(any_legal());
		foreach (buf_q[i])
			send_char(buf_q[i], i == buf_q.size() - 1);
	endtask

	// raw noise over the whole character range
	task automatic send_noise_text();
		int n;
		n = $urandom_range(1, 8);
		for (int i = 0; i < n; i++)
			send_char(8'($urandom_range(0, 255)), i == n - 1);
	endtask

	// output side: checks every taken word, random stalls and one long hold-off
	initial begin
		int  stall_left;
		int  hold_left;
		bit  hold_done;
		stall_left  = 0;
		hold_left   = 0;
		hold_done   = 1'b0;
		bytes.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (bytes.valid && bytes.ready)
				tracker.check_word('{data: bytes.out_byte, has_data: bytes.byte_valid,
					item_end: bytes.run_last, text_end: bytes.string_done});
			// long hold-off so the queue fills and the input side backs up
			if (!hold_done && tracker.checked >= HOLD_AT) begin
				hold_done = 1'b1;
				hold_left = HOLD_LEN;
			end
			if (hold_left > 0) begin
				hold_left--;
				bytes.ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				bytes.ready <= 1'b0;
			end else begin
				bytes.ready <= 1'b1;
				stall_left = pick_gap();
			end
		end
	end

	initial begin
		int  drain;
		bit  paused;
		tracker    = new;
		chars_sent = 0;
		texts_sent = 0;
		calm       = 1'b0;
		paused     = 1'b0;

		arst_n            = 1'b0;
		chars.valid       = 1'b0;
		chars.in_char     = 8'd0;
		chars.end_of_text = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// full group ending the text
		send_text("TWFu");
		// top of each alphabet range, then a two-sextet tail flushed by the end flag
		send_text("/+z9Za");
		// pad after three sextets gives two bytes, end flag on the pad itself
		send_text("QUI=");
		// lone sextet cut off by a high bad character: no bytes, end marker
		send_char("Q", 1'b0);
		send_char(8'hff, 1'b1);
		// bad character that is also the end of text
		send_char(8'h80, 1'b1);
		// pad first, then ignored characters while halted, end marker
		send_char(CH_PAD, 1'b0);
		send_char(8'h00, 1'b0);
		send_char("A", 1'b1);
		// single sextet ended by the flag
		send_char("0", 1'b1);

		while (chars_sent < TEXT_GOAL) begin
			// no idling on either side for a stretch of the run
			calm = (chars_sent >= 150 && chars_sent < 190);
			// once, let everything drain before going on
			if (!paused && chars_sent >= 210) begin
				paused = 1'b1;
				chars.valid <= 1'b0;
				do
					@(posedge clk);
				while (!tracker.idle());
			end
			if ($urandom_range(0, 3) != 0)
				send_good_text();
			else
				send_noise_text();
		end
		calm = 1'b0;
		chars.valid <= 1'b0;

		drain = 0;
		while (!tracker.idle() && drain < DRAIN_MAX) begin
			@(posedge clk);
			drain++;
		end
		repeat (20) @(posedge clk);

		$display("run covered %0d characters in %0d texts, %0d output words checked",
			chars_sent, texts_sent, tracker.checked);
		$display("%0d of them were empty end markers, %0d words still owed",
			tracker.markers, tracker.owed.size());
		if (tracker.failures == 0 && tracker.idle()) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

	// watchdog well beyond the slowest legal run
	initial begin
		#5ms;
		$display("FAILED: results differ");
		$finish;
	end

endmodule
